### src/date_difference_in_days_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the date difference block
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH

// same-cycle implication
`define DD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dd_pkg.sv
// ---------------------------------------------------------------------------
// dd_pkg
// Widths, constants, month table and stage control type for the day-number
// pipeline.
// ---------------------------------------------------------------------------
package dd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DAYNUM_W = 23;   // up to ~5.98M for year 16383
  localparam int DIST_W   = 22;
  localparam int MB_W     = 9;    // days of whole months, up to 365
  localparam int EXTRA_W  = 10;   // months + leap + day

  // x / 100 == (x * 5243) >> 19 for any x below 2^14
  localparam int              RECIP_W   = 13;
  localparam logic [12:0]     RECIP100  = 13'd5243;
  localparam int              RECIP_SH  = 19;
  localparam int              PROD_W    = YEAR_W + RECIP_W;      // 27
  localparam int              Q4_W      = YEAR_W - 2;            // 12
  localparam int              PROD4_W   = Q4_W + RECIP_W;        // 25
  localparam int              Q100_W    = PROD_W - RECIP_SH;     // 8
  localparam int              Q400_W    = PROD4_W - RECIP_SH;    // 6
  localparam int              CENT_W    = YEAR_W + 1;            // qy * 100

  localparam logic [DAYNUM_W-1:0] DAYS_PER_YEAR = DAYNUM_W'(365);
  localparam logic [CENT_W-1:0]   CENTURY       = CENT_W'(100);
  localparam logic [DAYNUM_W-1:0] DIST_MAX      = DAYNUM_W'(4194303);

  // per-stage load enables of the day-number pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // days of all whole months before month m in a common year;
  // month zero acts as January, anything past twelve as a full year
  function automatic logic [MB_W-1:0] months_before(input logic [MONTH_W-1:0] m);
    logic [MB_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

### src/date_difference_in_days.sv
// ---------------------------------------------------------------------------
// date_difference_in_days
// Absolute distance in days between two proleptic Gregorian dates.
// ---------------------------------------------------------------------------
// Each beat on the input stream carries two dates; each date is mapped to a
// day number counted from 0001-01-01 (whole years with the 4/100/400 leap
// rule, whole months from a fixed table with a leap day after February, plus
// the day), and one output beat carries the absolute difference, saturated
// to 22 bits. Days are not checked against month length, month zero acts as
// January, months above twelve as a full year. An input beat passes through
// three day-number stages (reciprocal products for the divides by 100 and
// 400, then term sums) and one subtract/saturate stage feeding the output
// register. A new beat is taken every cycle unless back-pressure has filled
// the pipeline; each stage holds only while it is full and the stage after
// it cannot load, so bubbles are squeezed out during back-pressure. No state
// beyond the pipeline valid bits; no setup after reset.
module date_difference_in_days import dd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [21:0] day_distance, [23:22] zero
  output logic [23:0] out_tdata
);

`include "date_difference_in_days_defines.svh"

  // valid bits, one per stage
  logic v1_r, v2_r, v3_r, v4_r;
  stage_en_t en;
  logic      en4;

  assign en4   = !v4_r || out_tready;
  assign en.s3 = !v3_r || en4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;
  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en4)   v4_r <= v3_r;
    end
  end

  logic [DAYNUM_W-1:0] dn_a, dn_b;

  dd_daynum u_first (
    .clk    (clk),
    .en     (en),
    .day    (in_tdata[4:0]),
    .month  (in_tdata[8:5]),
    .year   (in_tdata[22:9]),
    .daynum (dn_a)
  );

  dd_daynum u_second (
    .clk    (clk),
    .en     (en),
    .day    (in_tdata[27:23]),
    .month  (in_tdata[31:28]),
    .year   (in_tdata[45:32]),
    .daynum (dn_b)
  );

  // stage 4: absolute difference, clamp to the 22-bit range
  logic [DAYNUM_W-1:0] diff;
  logic [DIST_W-1:0]   dist_nxt, dist_r;

  assign diff     = (dn_a >= dn_b) ? dn_a - dn_b : dn_b - dn_a;
  assign dist_nxt = (diff > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : diff[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {2'b00, dist_r};

  // full and blocked pipeline must refuse input
  `DD_ASSERT_NOW(a_full_stall, v1_r && v2_r && v3_r && v4_r && !out_tready, !in_tready, "input taken while pipeline full and stalled")
  // a held result stays put until taken
  `DD_ASSERT_NEXT(a_hold_result, v4_r && !out_tready, v4_r && $stable(dist_r), "pending result changed")
  // a beat in stage 3 with a free output register moves on
  `DD_ASSERT_NEXT(a_advance, v3_r && en4, v4_r, "stage 3 beat lost")

endmodule

### src/dd_daynum.sv
// ---------------------------------------------------------------------------
// dd_daynum
// Three-stage conversion of one date into its day number from 0001-01-01.
// ---------------------------------------------------------------------------
module dd_daynum import dd_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [DAY_W-1:0]    day,
  input  logic [MONTH_W-1:0]  month,
  input  logic [YEAR_W-1:0]   year,
  output logic [DAYNUM_W-1:0] daynum
);

  // stage 1: years before, reciprocal products, month table
  logic [YEAR_W-1:0]  p_r, p_nxt;
  logic [Q4_W-1:0]    q4_r;
  logic [PROD_W-1:0]  pprod_r, yprod_r;
  logic [YEAR_W-1:0]  yr_r;
  logic [MB_W-1:0]    mb_r;
  logic               late_r;
  logic [DAY_W-1:0]   day_r;

  assign p_nxt = (year != '0) ? year - YEAR_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_r     <= p_nxt;
      q4_r    <= p_nxt[YEAR_W-1:2];
      pprod_r <= PROD_W'(p_nxt) * PROD_W'(RECIP100);
      yprod_r <= PROD_W'(year) * PROD_W'(RECIP100);
      yr_r    <= year;
      mb_r    <= months_before(month);
      late_r  <= (month > MONTH_W'(2));
      day_r   <= day;
    end
  end

  // stage 2: 365*p + p/4, p/100, product for p/400, leap test, small terms
  logic [Q100_W-1:0]   qy;
  logic [CENT_W-1:0]   cent;
  logic                leap;
  logic [DAYNUM_W-1:0] base_r;
  logic [Q100_W-1:0]   q100_r;
  logic [PROD4_W-1:0]  q4prod_r;
  logic [EXTRA_W-1:0]  extra_r;

  assign qy   = yprod_r[PROD_W-1:RECIP_SH];
  assign cent = CENT_W'(qy) * CENTURY;
  // divisible by 100 -> leap only if the century count is a multiple of 4
  assign leap = ({1'b0, yr_r} == cent) ? (qy[1:0] == 2'b00) : (yr_r[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base_r   <= DAYNUM_W'(p_r) * DAYS_PER_YEAR + DAYNUM_W'(q4_r);
      q100_r   <= pprod_r[PROD_W-1:RECIP_SH];
      q4prod_r <= PROD4_W'(q4_r) * PROD4_W'(RECIP100);
      extra_r  <= EXTRA_W'(mb_r) + EXTRA_W'(late_r & leap) + EXTRA_W'(day_r);
    end
  end

  // stage 3: gather the terms
  logic [Q400_W-1:0]   q400;
  logic [DAYNUM_W-1:0] daynum_r;

  assign q400 = q4prod_r[PROD4_W-1:RECIP_SH];

  always_ff @(posedge clk) begin
    if (en.s3) begin
      daynum_r <= base_r - DAYNUM_W'(q100_r) + DAYNUM_W'(q400) + DAYNUM_W'(extra_r);
    end
  end

  assign daynum = daynum_r;

endmodule

### dv/tb_date_difference_in_days.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_date_difference_in_days
// Self-checking stream testbench for the date distance pipeline. Date pairs
// go in as input beats. A day-number predictor inside the bench computes the
// expected distance of each accepted beat and queues it. Every output beat is
// checked in order against that queue. Random gaps are inserted on the input
// side and random stalls on the output side.
// ---------------------------------------------------------------------------
module tb_date_difference_in_days import dd_pkg::*;;

  localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int unsigned LONG_HOLD  = 300;   // receiver hold-off that fills the pipe
  localparam int unsigned SETTLE     = 8;     // settle time after the expectation queue drains
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  // days of the whole months before month m, common year; index 13 = full year
  localparam int unsigned DAYS_BEFORE_MONTH [14] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [21:0] day_distance, [23:22] zero
  logic [23:0] out_tdata;

  logic [DIST_W-1:0] expected_distances [$];
  logic [DIST_W-1:0] expected_head;
  int unsigned       error_count = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       sink_hold_left = 0;

  // traffic shaping knobs, set by the test tasks
  bit src_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;
  bit sink_long_hold_req = 1'b0;
  bit source_idle = 1'b1;        // mirrors in_tvalid without waiting on NBA update

  date_difference_in_days u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Day-number predictor
  // -------------------------------------------------------------------------
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // day number from 0001-01-01 (= 1); out-of-range fields follow the
  // block: month 0 acts as January, months past 12 as a whole year,
  // year 0 has no years before it but counts as leap for February
  function automatic int unsigned day_number_of(input date_t d);
    int unsigned yr;
    int unsigned past_years;
    int unsigned month_idx;
    int unsigned total;
    yr = int'(d.year);
    past_years = (yr > 0) ? yr - 1 : 0;
    total = 365 * past_years + past_years / 4 - past_years / 100 + past_years / 400;
    month_idx = (int'(d.month) > 13) ? 13 : int'(d.month);
    total += DAYS_BEFORE_MONTH[month_idx];
    if (month_idx > 2 && is_leap_year(yr))
      total += 1;
    return total + int'(d.day);
  endfunction

  function automatic logic [DIST_W-1:0] predict_day_distance(input date_t a, input date_t b);
    int unsigned na;
    int unsigned nb;
    int unsigned distance;
    na = day_number_of(a);
    nb = day_number_of(b);
    distance = (na >= nb) ? na - nb : nb - na;
    if (distance > int'(DIST_SAT))
      distance = int'(DIST_SAT);
    return distance[DIST_W-1:0];
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t r;
    r.day = d[DAY_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.year = y[YEAR_W-1:0];
    return r;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    if (m == 2)
      return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11)
      return 30;
    return 31;
  endfunction

  // well-formed calendar date inside the given year
  function automatic date_t calendar_date_in(input int unsigned y);
    int unsigned m;
    m = $urandom_range(12, 1);
    return mk_date($urandom_range(days_in_month(m, y), 1), m, y);
  endfunction

  // any bit pattern the fields can carry
  function automatic date_t raw_date();
    date_t r;
    r.day = DAY_W'($urandom);
    r.month = MONTH_W'($urandom);
    r.year = YEAR_W'($urandom);
    return r;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70)
      return $urandom_range(3, 1);
    if (roll < 95)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one date pair and hold it until accepted. The expectation is
  // queued at the accepting edge. Valid stays up unless a gap is drawn, so
  // back-to-back calls stream one beat per cycle while in_tready stays high.
  task automatic send_date_pair(input date_t first, input date_t second);
    int unsigned gap;
    in_tdata <= {2'b00, second, first};
    in_tvalid <= 1'b1;
    source_idle = 1'b0;
    do @(posedge clk); while (!in_tready);
    expected_distances.push_back(predict_day_distance(first, second));
    if (src_gaps_on && $urandom_range(99) < 30) begin
      gap = idle_length();
      in_tvalid <= 1'b0;
      source_idle = 1'b1;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid (once) so a held beat is not taken twice while we wait
  task automatic release_source();
    if (!source_idle) begin
      in_tvalid <= 1'b0;
      source_idle = 1'b1;
    end
  endtask

  task automatic wait_results_drained();
    while (expected_distances.size() != 0)
      @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // field extremes: all-zero and all-one patterns, the calendar span, and
  // the saturating corner
  task automatic test_field_extremes();
    send_date_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));             // zero distance
    send_date_pair(mk_date(1, 1, 1), mk_date(31, 12, 9999));        // full span
    send_date_pair(mk_date(31, 12, 9999), mk_date(1, 1, 1));        // operands swapped
    send_date_pair(mk_date(0, 0, 0), mk_date(0, 0, 0));
    send_date_pair(mk_date(0, 0, 0), mk_date(1, 1, 1));             // day zero adds nothing
    send_date_pair(mk_date(31, 15, 16383), mk_date(0, 0, 0));       // saturates
    send_date_pair(mk_date(0, 0, 0), mk_date(31, 15, 16383));
    send_date_pair(mk_date(31, 15, 16383), mk_date(31, 15, 16383));
    send_date_pair(mk_date(1, 1, 11483), mk_date(1, 1, 1));         // just under the 22-bit edge
    send_date_pair(mk_date(1, 1, 11482), mk_date(1, 1, 1));         // just under it
  endtask

  // day overflow, odd months, year zero and the leap rules
  task automatic test_special_cases();
    send_date_pair(mk_date(31, 4, 2023), mk_date(1, 5, 2023));      // day past month end
    send_date_pair(mk_date(10, 0, 2000), mk_date(10, 1, 2000));     // month zero = January
    send_date_pair(mk_date(5, 13, 1999), mk_date(5, 1, 2000));      // month 13 rolls over
    send_date_pair(mk_date(5, 15, 1999), mk_date(0, 1, 2000));      // month 15, day 5 extra
    send_date_pair(mk_date(1, 3, 0), mk_date(1, 3, 1));             // year zero is leap
    send_date_pair(mk_date(1, 1, 0), mk_date(1, 1, 1));
    send_date_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));      // 400-year leap
    send_date_pair(mk_date(28, 2, 1900), mk_date(1, 3, 1900));      // century, not leap
    send_date_pair(mk_date(28, 2, 2024), mk_date(1, 3, 2024));      // ordinary leap
    send_date_pair(mk_date(1, 3, 2100), mk_date(1, 3, 2099));
    send_date_pair(mk_date(31, 12, 2399), mk_date(1, 1, 2401));
    send_date_pair(mk_date(15, 6, 2024), mk_date(15, 6, 2023));
  endtask

  // four blocks cycle through every combination of input gaps and output
  // stalls; most pairs are real calendar dates, some share a year, the
  // rest are raw bit patterns
  task automatic test_random_dates(input int unsigned count);
    date_t a;
    date_t b;
    int unsigned roll;
    for (int blk = 0; blk < 4; blk++) begin
      src_gaps_on = (blk % 2) == 1;
      sink_stalls_on = blk >= 2;
      for (int unsigned i = 0; i < count / 4; i++) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          a = calendar_date_in($urandom_range(9999, 1));
          b = calendar_date_in($urandom_range(9999, 1));
        end else if (roll < 85) begin
          a = calendar_date_in($urandom_range(9999, 1));
          b = calendar_date_in(int'(a.year));
        end else begin
          a = raw_date();
          b = raw_date();
        end
        send_date_pair(a, b);
      end
    end
  endtask

  // receiver holds off for a long stretch while beats keep coming, so the
  // pipe fills and in_tready drops
  task automatic test_output_backpressure();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    sink_long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_date_pair(calendar_date_in($urandom_range(9999, 1)),
                     calendar_date_in($urandom_range(9999, 1)));
  endtask

  // sender goes quiet until the pipe is empty, then resumes
  task automatic test_drain_pause();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    for (int i = 0; i < 40; i++)
      send_date_pair(raw_date(), calendar_date_in($urandom_range(9999, 1)));
    release_source();
    wait_results_drained();
    for (int i = 0; i < 40; i++)
      send_date_pair(calendar_date_in($urandom_range(9999, 1)), raw_date());
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_tready <= 1'b0;
    end else if (sink_long_hold_req) begin
      sink_long_hold_req = 1'b0;
      sink_hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(99) < 25) begin
      sink_hold_left = idle_length() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Result check: each output beat against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_distances.size() == 0) begin
        $error("day_distance: unexpected beat, expected none, actual %0d",
               out_tdata[DIST_W-1:0]);
        error_count++;
      end else begin
        expected_head = expected_distances.pop_front();
        if (out_tdata[DIST_W-1:0] !== expected_head) begin
          $error("day_distance mismatch: expected %0d, actual %0d",
                 expected_head, out_tdata[DIST_W-1:0]);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long with no beat on either side means a hang
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_special_cases();
    test_random_dates(1680);
    test_output_backpressure();
    test_drain_pause();
    release_source();
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_distances.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_distances.size() != 0)
        $error("day_distance: %0d expected beats never arrived",
               expected_distances.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/dd_pkg.sv
src/dd_daynum.sv
src/date_difference_in_days.sv
dv/tb_date_difference_in_days.sv
